FILE: rtl/core/tcw_pkg.sv
// tcw_pkg: shared types and constants of the text console writer
// op codes, character codes, config indexes and reset values, queue sizes and the classified command
// no dependencies
`default_nettype none

package tcw_pkg;

  // input op codes
  localparam logic [2:0] OP_PUT_CHAR   = 3'd0;
  localparam logic [2:0] OP_WRITE_CELL = 3'd1;
  localparam logic [2:0] OP_READ_CELL  = 3'd2;
  localparam logic [2:0] OP_SCROLL     = 3'd3;
  localparam logic [2:0] OP_CLEAR      = 3'd4;

  // character codes
  localparam logic [7:0] CHAR_NUL     = 8'h00;
  localparam logic [7:0] CHAR_TAB     = 8'h09;
  localparam logic [7:0] CHAR_NEWLINE = 8'h0a;
  localparam logic [7:0] CHAR_SPACE   = 8'h20;

  // config register indexes
  localparam int unsigned CFG_INDEX_W = 2;
  localparam logic [CFG_INDEX_W-1:0] CFG_ROW_COUNT    = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_COLUMN_COUNT = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_ATTRIBUTE    = 2'd2;

  // config reset values
  localparam logic [5:0] ROW_COUNT_RESET    = 6'd25;
  localparam logic [7:0] COLUMN_COUNT_RESET = 8'd80;
  localparam logic [7:0] ATTRIBUTE_RESET    = 8'h0f;

  // command queue between front and back
  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QUEUE_PTR_W = 1;
  localparam int unsigned QUEUE_CNT_W = 2;

  typedef enum logic [2:0] {
    CMD_NOP,
    CMD_CHAR,
    CMD_TAB,
    CMD_NEWLINE,
    CMD_WRITE,
    CMD_READ,
    CMD_SCROLL,
    CMD_CLEAR
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t   kind;
    logic [7:0]  char_code;
    logic [4:0]  cell_row;
    logic [6:0]  cell_column;
    logic [5:0]  scroll_lines;
  } cmd_t;

endpackage

`default_nettype wire

FILE: rtl/core/text_console_writer.sv
// text_console_writer: text-mode console engine with scrolling, top level
// instantiates tcw_front, tcw_queue and tcw_back; depends on tcw_pkg
//
//  channel | direction | handshake               | payload
//  in_     | input     | in_valid / in_stall     | op, char_code, cell_row, cell_column,
//          |           |                         | scroll_lines
//  out_    | output    | out_valid / out_stall   | cell_char, cursor_row, cursor_column
//  cfg_    | input     | cfg_valid / cfg_ready   | cfg_index, cfg_data
//
// a plain character passes the back end sequencer through fetch, execute,
// cursor step and result; a cell write, cell read or no-op has no cursor step
// tab pads with spaces to the next tab stop, newline to the last column in use,
// one cell write per cycle on the single write port of the screen memory
// scroll and clear go over every cell of the rows and columns in use, and a
// put char that runs past the last row adds a one-line scroll over the same cells
// the screen memory is not cleared at reset; cursor and config reset at once
// a two-entry command queue keeps taking beats while the back end works or
// while a result waits under out_stall
`default_nettype none

module text_console_writer #(
  parameter int unsigned MAX_ROWS    = 32,
  parameter int unsigned MAX_COLUMNS = 128,
  parameter int unsigned TAB_WIDTH   = 4
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            in_valid,
  output logic                                 in_stall,
  input  wire logic [2:0]                      in_op,
  input  wire logic [7:0]                      in_char_code,
  input  wire logic [4:0]                      in_cell_row,
  input  wire logic [6:0]                      in_cell_column,
  input  wire logic [5:0]                      in_scroll_lines,
  output logic                                 out_valid,
  input  wire logic                            out_stall,
  output logic [7:0]                           out_cell_char,
  output logic [4:0]                           out_cursor_row,
  output logic [6:0]                           out_cursor_column,
  input  wire logic                            cfg_valid,
  output logic                                 cfg_ready,
  input  wire logic [tcw_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [7:0]                      cfg_data
);
  import tcw_pkg::*;

  logic q_full, q_push, q_pop, q_valid;
  cmd_t push_cmd, head_cmd;

  assign cfg_ready = 1'b1;

  tcw_front #(
    .MAX_ROWS    (MAX_ROWS),
    .MAX_COLUMNS (MAX_COLUMNS)
  ) u_front (
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_op           (in_op),
    .in_char_code    (in_char_code),
    .in_cell_row     (in_cell_row),
    .in_cell_column  (in_cell_column),
    .in_scroll_lines (in_scroll_lines),
    .q_full          (q_full),
    .q_push          (q_push),
    .q_push_cmd      (push_cmd)
  );

  tcw_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_cmd (push_cmd),
    .full     (q_full),
    .pop      (q_pop),
    .valid    (q_valid),
    .head_cmd (head_cmd)
  );

  tcw_back #(
    .MAX_ROWS    (MAX_ROWS),
    .MAX_COLUMNS (MAX_COLUMNS),
    .TAB_WIDTH   (TAB_WIDTH)
  ) u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_we            (cfg_valid && cfg_ready),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .q_valid           (q_valid),
    .q_cmd             (head_cmd),
    .q_pop             (q_pop),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_cell_char     (out_cell_char),
    .out_cursor_row    (out_cursor_row),
    .out_cursor_column (out_cursor_column)
  );

endmodule

`default_nettype wire

FILE: rtl/core/tcw_front.sv
// tcw_front: accepts input beats and classifies them into commands
// depends on tcw_pkg; feeds tcw_queue
`default_nettype none

module tcw_front #(
  parameter int unsigned MAX_ROWS    = 32,
  parameter int unsigned MAX_COLUMNS = 128
) (
  input  wire logic          in_valid,
  output logic               in_stall,
  input  wire logic [2:0]    in_op,
  input  wire logic [7:0]    in_char_code,
  input  wire logic [4:0]    in_cell_row,
  input  wire logic [6:0]    in_cell_column,
  input  wire logic [5:0]    in_scroll_lines,
  input  wire logic          q_full,
  output logic               q_push,
  output tcw_pkg::cmd_t      q_push_cmd
);
  import tcw_pkg::*;

  logic in_store;

  // cell addressed by write cell or read cell lies inside the store
  assign in_store = ({2'b00, in_cell_row} < 7'(MAX_ROWS)) &&
                    ({2'b00, in_cell_column} < 9'(MAX_COLUMNS));

  assign in_stall = q_full;
  assign q_push   = in_valid && !q_full;

  always_comb begin
    q_push_cmd.kind         = CMD_NOP;
    q_push_cmd.char_code    = in_char_code;
    q_push_cmd.cell_row     = in_cell_row;
    q_push_cmd.cell_column  = in_cell_column;
    q_push_cmd.scroll_lines = in_scroll_lines;
    case (in_op)
      OP_PUT_CHAR: begin
        if (in_char_code == CHAR_NUL) begin
          q_push_cmd.kind = CMD_NOP;
        end else if (in_char_code == CHAR_TAB) begin
          q_push_cmd.kind = CMD_TAB;
        end else if (in_char_code == CHAR_NEWLINE) begin
          q_push_cmd.kind = CMD_NEWLINE;
        end else begin
          q_push_cmd.kind = CMD_CHAR;
        end
      end
      OP_WRITE_CELL: q_push_cmd.kind = in_store ? CMD_WRITE : CMD_NOP;
      // a read outside the store answers zero, same as a no-op
      OP_READ_CELL:  q_push_cmd.kind = in_store ? CMD_READ : CMD_NOP;
      OP_SCROLL:     q_push_cmd.kind = CMD_SCROLL;
      OP_CLEAR:      q_push_cmd.kind = CMD_CLEAR;
      default:       q_push_cmd.kind = CMD_NOP;
    endcase
  end

endmodule

`default_nettype wire

FILE: rtl/core/tcw_queue.sv
// tcw_queue: short command queue between the front and the back
// depends on tcw_pkg
`default_nettype none

module tcw_queue (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          push,
  input  wire tcw_pkg::cmd_t push_cmd,
  output logic               full,
  input  wire logic          pop,
  output logic               valid,
  output tcw_pkg::cmd_t      head_cmd
);
  import tcw_pkg::*;

  cmd_t                   slot_r [QUEUE_DEPTH];
  logic [QUEUE_PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QUEUE_PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QUEUE_CNT_W-1:0] count_r, count_nxt;
  logic                   do_push, do_pop;

  assign full     = (count_r == QUEUE_CNT_W'(QUEUE_DEPTH));
  assign valid    = (count_r != '0);
  assign head_cmd = slot_r[rd_ptr_r];
  assign do_push  = push && !full;
  assign do_pop   = pop && valid;

  always_comb begin
    wr_ptr_nxt = do_push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = do_pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r;
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= push_cmd;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= QUEUE_CNT_W'(QUEUE_DEPTH))
    else $error("queue count beyond depth");

  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    full |-> !push)
    else $error("push offered while queue full");

  a_pop_valid: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> valid)
    else $error("pop from empty queue");

endmodule

`default_nettype wire

FILE: rtl/core/tcw_back.sv
// tcw_back: executes commands on the screen store and keeps the cursor
// holds config registers, the cell memory and the result register; depends on tcw_pkg
`default_nettype none

module tcw_back #(
  parameter int unsigned MAX_ROWS    = 32,
  parameter int unsigned MAX_COLUMNS = 128,
  parameter int unsigned TAB_WIDTH   = 4
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            cfg_we,
  input  wire logic [tcw_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [7:0]                      cfg_data,
  input  wire logic                            q_valid,
  input  wire tcw_pkg::cmd_t                   q_cmd,
  output logic                                 q_pop,
  output logic                                 out_valid,
  input  wire logic                            out_stall,
  output logic [7:0]                           out_cell_char,
  output logic [4:0]                           out_cursor_row,
  output logic [6:0]                           out_cursor_column
);
  import tcw_pkg::*;

  localparam int RW    = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int CW    = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;
  localparam int LW    = $clog2(MAX_ROWS + 1);
  localparam int PW    = $clog2(MAX_COLUMNS + 1);
  localparam int PHW   = (TAB_WIDTH > 1) ? $clog2(TAB_WIDTH) : 1;
  localparam int AW    = RW + CW;
  localparam int DEPTH = 1 << AW;

  typedef enum logic [7:0] {
    S_IDLE   = 8'b0000_0001,
    S_EXEC   = 8'b0000_0010,
    S_LINE   = 8'b0000_0100,
    S_ADV    = 8'b0000_1000,
    S_COPY   = 8'b0001_0000,
    S_DRAIN  = 8'b0010_0000,
    S_FILL   = 8'b0100_0000,
    S_FINISH = 8'b1000_0000
  } state_t;

  state_t          state_r, state_nxt;
  logic [LW-1:0]   line_r, line_nxt;
  logic [PW-1:0]   pos_r, pos_nxt;
  logic [PHW-1:0]  phase_r, phase_nxt;
  cmd_t            cmd_r, cmd_nxt;
  logic [5:0]      row_count_r;
  logic [7:0]      column_count_r;
  logic [7:0]      attribute_r;
  logic [LW-1:0]   cnt_r, cnt_nxt;
  logic [LW-1:0]   dst_r, dst_nxt;
  logic [LW-1:0]   src_r, src_nxt;
  logic [PW-1:0]   col_r, col_nxt;
  logic            scroll_r, scroll_nxt;
  logic            putc_r, putc_nxt;
  logic            rdflag_r, rdflag_nxt;
  logic            pend_r, pend_nxt;
  logic [AW-1:0]   pend_addr_r, pend_addr_nxt;
  logic            out_valid_r, out_valid_nxt;
  logic [7:0]      out_char_r, out_char_nxt;
  logic [4:0]      out_row_r, out_row_nxt;
  logic [6:0]      out_col_r, out_col_nxt;

  logic [15:0]     mem [DEPTH];
  logic [15:0]     rd_data_r;
  logic            mem_we, mem_re;
  logic [AW-1:0]   mem_waddr, mem_raddr;
  logic [15:0]     mem_wdata;

  logic [6:0]      rc_ext, rows_ext, rows_m1_ext, lines_ext, scroll_cnt_ext;
  logic [8:0]      cc_ext, cols_ext;
  logic [LW-1:0]   rows, scroll_cnt, line_inc, line_wrap, line_dec, line_end;
  logic [PW-1:0]   cols, pos_inc;
  logic [PHW-1:0]  phase_inc;
  logic            pos_at_end, line_stop, out_free;
  logic [AW-1:0]   cursor_addr, cell_addr;
  logic [RW+4:0]   cell_row_ext;
  logic [CW+6:0]   cell_col_ext;
  logic [LW+4:0]   line_ext;
  logic [PW+6:0]   pos_ext;

  // counts in use, with zero taken as one and large values capped
  assign rc_ext   = {1'b0, row_count_r};
  assign rows_ext = (row_count_r == '0) ? 7'd1 :
                    (rc_ext > 7'(MAX_ROWS)) ? 7'(MAX_ROWS) : rc_ext;
  assign rows     = rows_ext[LW-1:0];
  assign cc_ext   = {1'b0, column_count_r};
  assign cols_ext = (column_count_r == '0) ? 9'd1 :
                    (cc_ext > 9'(MAX_COLUMNS)) ? 9'(MAX_COLUMNS) : cc_ext;
  assign cols     = cols_ext[PW-1:0];

  // scroll count clamped to rows - 1
  assign rows_m1_ext    = rows_ext - 7'd1;
  assign lines_ext      = {1'b0, cmd_r.scroll_lines};
  assign scroll_cnt_ext = (lines_ext > rows_m1_ext) ? rows_m1_ext : lines_ext;
  assign scroll_cnt     = scroll_cnt_ext[LW-1:0];

  assign pos_inc    = pos_r + 1'b1;
  assign phase_inc  = (phase_r == PHW'(TAB_WIDTH - 1)) ? '0 : phase_r + 1'b1;
  assign pos_at_end = (pos_r >= cols);
  assign line_inc   = line_r + 1'b1;
  assign line_wrap  = pos_at_end ? line_inc : line_r;
  assign line_dec   = (line_r > cnt_r) ? line_r - cnt_r : '0;
  assign line_end   = (putc_r && (line_dec >= rows)) ? rows - 1'b1 : line_dec;

  // tab stops at the next tab column, both stop at the last column
  assign line_stop  = (pos_inc >= cols) ||
                      ((cmd_r.kind == CMD_TAB) && (phase_inc == '0));

  assign cursor_addr  = {line_r[RW-1:0], pos_r[CW-1:0]};
  assign cell_row_ext = {RW'(0), cmd_r.cell_row};
  assign cell_col_ext = {CW'(0), cmd_r.cell_column};
  assign cell_addr    = {cell_row_ext[RW-1:0], cell_col_ext[CW-1:0]};

  assign line_ext = {5'b0, line_r};
  assign pos_ext  = {7'b0, pos_r};
  assign out_free = !out_valid_r || !out_stall;

  always_comb begin
    state_nxt     = state_r;
    line_nxt      = line_r;
    pos_nxt       = pos_r;
    phase_nxt     = phase_r;
    cmd_nxt       = cmd_r;
    cnt_nxt       = cnt_r;
    dst_nxt       = dst_r;
    src_nxt       = src_r;
    col_nxt       = col_r;
    scroll_nxt    = scroll_r;
    putc_nxt      = putc_r;
    rdflag_nxt    = rdflag_r;
    pend_nxt      = 1'b0;
    pend_addr_nxt = pend_addr_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_char_nxt  = out_char_r;
    out_row_nxt   = out_row_r;
    out_col_nxt   = out_col_r;
    q_pop         = 1'b0;
    mem_we        = 1'b0;
    mem_waddr     = cursor_addr;
    mem_wdata     = {attribute_r, CHAR_SPACE};
    mem_re        = 1'b0;
    mem_raddr     = cell_addr;

    case (state_r)
      S_IDLE: begin
        if (q_valid) begin
          q_pop      = 1'b1;
          cmd_nxt    = q_cmd;
          rdflag_nxt = 1'b0;
          state_nxt  = S_EXEC;
        end
      end

      S_EXEC: begin
        case (cmd_r.kind)
          CMD_CHAR: begin
            mem_we    = 1'b1;
            mem_wdata = {attribute_r, cmd_r.char_code};
            pos_nxt   = pos_inc;
            phase_nxt = phase_inc;
            state_nxt = S_ADV;
          end
          CMD_TAB, CMD_NEWLINE: begin
            state_nxt = pos_at_end ? S_ADV : S_LINE;
          end
          CMD_WRITE: begin
            mem_we    = 1'b1;
            mem_waddr = cell_addr;
            mem_wdata = {attribute_r, cmd_r.char_code};
            state_nxt = S_FINISH;
          end
          CMD_READ: begin
            mem_re     = 1'b1;
            rdflag_nxt = 1'b1;
            state_nxt  = S_FINISH;
          end
          CMD_SCROLL: begin
            if (scroll_cnt == '0) begin
              state_nxt = S_FINISH;
            end else begin
              cnt_nxt    = scroll_cnt;
              dst_nxt    = '0;
              src_nxt    = scroll_cnt;
              col_nxt    = '0;
              scroll_nxt = 1'b1;
              putc_nxt   = 1'b0;
              state_nxt  = S_COPY;
            end
          end
          CMD_CLEAR: begin
            dst_nxt    = '0;
            col_nxt    = '0;
            scroll_nxt = 1'b0;
            putc_nxt   = 1'b0;
            state_nxt  = S_FILL;
          end
          default: state_nxt = S_FINISH;
        endcase
      end

      // pad with spaces for tab and newline
      S_LINE: begin
        mem_we    = 1'b1;
        pos_nxt   = pos_inc;
        phase_nxt = phase_inc;
        if (line_stop) begin
          state_nxt = S_ADV;
        end
      end

      // wrap the column, then scroll one line if past the last row (with one row in use, return to row 0)
      S_ADV: begin
        line_nxt = line_wrap;
        if (pos_at_end) begin
          pos_nxt   = '0;
          phase_nxt = '0;
        end
        if (line_wrap >= rows) begin
          if (rows == LW'(1)) begin
            line_nxt  = '0;
            state_nxt = S_FINISH;
          end else begin
            cnt_nxt    = LW'(1);
            dst_nxt    = '0;
            src_nxt    = LW'(1);
            col_nxt    = '0;
            scroll_nxt = 1'b1;
            putc_nxt   = 1'b1;
            state_nxt  = S_COPY;
          end
        end else begin
          state_nxt = S_FINISH;
        end
      end

      // read a cell of the source row, write it to the destination in the following beat
      S_COPY: begin
        mem_re        = 1'b1;
        mem_raddr     = {src_r[RW-1:0], col_r[CW-1:0]};
        pend_nxt      = 1'b1;
        pend_addr_nxt = {dst_r[RW-1:0], col_r[CW-1:0]};
        if (pend_r) begin
          mem_we    = 1'b1;
          mem_waddr = pend_addr_r;
          mem_wdata = {attribute_r, rd_data_r[7:0]};
        end
        if (col_r == cols - 1'b1) begin
          col_nxt = '0;
          src_nxt = src_r + 1'b1;
          dst_nxt = dst_r + 1'b1;
          if (src_r == rows - 1'b1) begin
            state_nxt = S_DRAIN;
          end
        end else begin
          col_nxt = col_r + 1'b1;
        end
      end

      S_DRAIN: begin
        mem_we    = pend_r;
        mem_waddr = pend_addr_r;
        mem_wdata = {attribute_r, rd_data_r[7:0]};
        state_nxt = S_FILL;
      end

      // space fill for vacated rows and for clear
      S_FILL: begin
        mem_we    = 1'b1;
        mem_waddr = {dst_r[RW-1:0], col_r[CW-1:0]};
        if (col_r == cols - 1'b1) begin
          col_nxt = '0;
          dst_nxt = dst_r + 1'b1;
          if (dst_r == rows - 1'b1) begin
            if (scroll_r) begin
              line_nxt = line_end;
            end
            state_nxt = S_FINISH;
          end
        end else begin
          col_nxt = col_r + 1'b1;
        end
      end

      S_FINISH: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_char_nxt  = rdflag_r ? rd_data_r[7:0] : 8'h00;
          out_row_nxt   = line_ext[4:0];
          out_col_nxt   = pos_ext[6:0];
          state_nxt     = S_IDLE;
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= S_IDLE;
      line_r         <= '0;
      pos_r          <= '0;
      phase_r        <= '0;
      row_count_r    <= ROW_COUNT_RESET;
      column_count_r <= COLUMN_COUNT_RESET;
      attribute_r    <= ATTRIBUTE_RESET;
      scroll_r       <= 1'b0;
      putc_r         <= 1'b0;
      rdflag_r       <= 1'b0;
      pend_r         <= 1'b0;
      out_valid_r    <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      line_r      <= line_nxt;
      pos_r       <= pos_nxt;
      phase_r     <= phase_nxt;
      scroll_r    <= scroll_nxt;
      putc_r      <= putc_nxt;
      rdflag_r    <= rdflag_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        case (cfg_index)
          CFG_ROW_COUNT:    row_count_r    <= cfg_data[5:0];
          CFG_COLUMN_COUNT: column_count_r <= cfg_data;
          CFG_ATTRIBUTE:    attribute_r    <= cfg_data;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    cmd_r       <= cmd_nxt;
    cnt_r       <= cnt_nxt;
    dst_r       <= dst_nxt;
    src_r       <= src_nxt;
    col_r       <= col_nxt;
    pend_addr_r <= pend_addr_nxt;
    out_char_r  <= out_char_nxt;
    out_row_r   <= out_row_nxt;
    out_col_r   <= out_col_nxt;
  end

  // screen store: one write and one registered read a cycle
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rd_data_r <= mem[mem_raddr];
    end
  end

  assign out_valid         = out_valid_r;
  assign out_cell_char     = out_char_r;
  assign out_cursor_row    = out_row_r;
  assign out_cursor_column = out_col_r;

  a_line_in_store: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE) |-> ({1'b0, line_r} < (LW+1)'(MAX_ROWS)))
    else $error("cursor row outside the store");

  a_pos_in_store: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE) |-> ({1'b0, pos_r} < (PW+1)'(MAX_COLUMNS)))
    else $error("cursor column outside the store");

  a_result_from_finish: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_FINISH))
    else $error("result loaded outside finish");

  a_pend_in_copy: assert property (@(posedge clk) disable iff (!rst_n)
    pend_r |-> (state_r == S_COPY || state_r == S_DRAIN))
    else $error("pending copy write outside scroll copy");

endmodule

`default_nettype wire
